// File: rtl/core/min_max_feature_normalizer_defines.svh
// assertion macros used by the normalizer sequencer (mmfn_ctrl)
`ifndef MIN_MAX_FEATURE_NORMALIZER_DEFINES_SVH
`define MIN_MAX_FEATURE_NORMALIZER_DEFINES_SVH

`ifndef ASSERT_OFF
`define MMFN_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("mmfn assertion failed");
`define MMFN_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("mmfn assertion failed");
`else
`define MMFN_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define MMFN_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/core/mmfn_pkg.sv
// types and constants of the min/max feature normalizer
`default_nettype none
package mmfn_pkg;

  localparam int VAL_W      = 32;
  localparam int FRAC_W     = 16;
  localparam int IDX_W      = 4;
  localparam int FC_W       = 5;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 5;
  localparam int DIV_STEPS  = 32;
  localparam int STEP_CNT_W = 5;

  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  localparam logic [CFG_ADDR_W-1:0] CFG_BYPASS        = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_FEATURE_COUNT = 1'b1;

  typedef enum logic [1:0] {
    OP_ACCUM = 2'd0,
    OP_NORM  = 2'd1,
    OP_CLEAR = 2'd2
  } opcode_t;

  typedef struct packed {
    opcode_t                  opcode;
    logic [IDX_W-1:0]         feature_index;
    logic signed [VAL_W-1:0]  sample_value;
  } in_item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0]  result_value;
    logic [IDX_W-1:0]         result_feature;
    logic                     range_degenerate;
    logic                     index_error;
  } out_item_t;

  typedef struct packed {
    logic load;      // capture accepted beat, read stats
    logic wr_stats;  // write back updated min/max
    logic clr_stats; // drop all stats
    logic eval;      // latch early result, diff and range
    logic abs_load;  // take magnitude of the diff
    logic div_init;  // overflow check, seed divider
    logic div_step;  // one restoring divide step
    logic out_load;  // move result into output register
  } dp_cmd_t;

  typedef struct packed {
    opcode_t opcode;
    logic    bad;
    logic    early;
  } dp_status_t;

endpackage
`default_nettype wire

// File: rtl/core/min_max_feature_normalizer.sv
// min_max_feature_normalizer: running per-column min/max and Q16.16 normalize
// one item at a time; accumulate or clear: the next beat can be taken once EXEC returns to IDLE
// normalize with a flag or bypass: EXEC goes straight to FIN and the divider is skipped
// normalize with divide: states EXEC, ABS and INIT, then DIV for the 32 steps of the
// radix-2 restoring divider, then FIN; a stalled output holds the input
// synchronous active-low reset: bypass off, feature count 16, all column stats empty
`default_nettype none
module min_max_feature_normalizer #(
  parameter int MAX_FEATURES = 16
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  mmfn_pkg::in_item_t         in_data,
  output logic                             out_valid,
  input  wire                              out_ready,
  output mmfn_pkg::out_item_t              out_data,
  input  wire                              cfg_we,
  input  wire  [mmfn_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire  [mmfn_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import mmfn_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  mmfn_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .status    (status)
  );

  mmfn_datapath #(
    .MAX_FEATURES (MAX_FEATURES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

endmodule
`default_nettype wire

// File: rtl/core/mmfn_datapath.sv
// stats memory, config registers, divider and output register
`default_nettype none
module mmfn_datapath #(
  parameter int MAX_FEATURES = 16
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire  mmfn_pkg::dp_cmd_t             cmd,
  output mmfn_pkg::dp_status_t                status,
  input  wire  mmfn_pkg::in_item_t            in_data,
  output mmfn_pkg::out_item_t                 out_data,
  input  wire                                 cfg_we,
  input  wire  [mmfn_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire  [mmfn_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import mmfn_pkg::*;

  localparam int ADDR_W = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int CNT_W  = ($clog2(MAX_FEATURES + 1) > FC_W) ? $clog2(MAX_FEATURES + 1) : FC_W;

  logic                    bypass_r;
  logic [FC_W-1:0]         fcount_r;

  logic signed [VAL_W-1:0] mem_min [MAX_FEATURES];
  logic signed [VAL_W-1:0] mem_max [MAX_FEATURES];
  logic [MAX_FEATURES-1:0] vld_r;

  in_item_t                item_r;
  logic signed [VAL_W-1:0] rd_min_r;
  logic signed [VAL_W-1:0] rd_max_r;
  logic                    rd_vld_r;

  logic                    early_r;
  out_item_t               early_res_r;
  logic signed [VAL_W:0]   diff_r;
  logic [VAL_W-1:0]        range_r;
  logic                    neg_r;
  logic [VAL_W-1:0]        mag_r;
  logic                    ovf_r;
  logic [VAL_W-1:0]        rem_r;
  logic [VAL_W-1:0]        dvd_r;
  out_item_t               out_r;

  logic [ADDR_W+IDX_W-1:0] rd_wide;
  logic [ADDR_W+IDX_W-1:0] wr_wide;
  logic [ADDR_W-1:0]       rd_addr;
  logic [ADDR_W-1:0]       wr_addr;
  logic [CNT_W-1:0]        active;
  logic                    bad;
  logic signed [VAL_W-1:0] lo;
  logic signed [VAL_W-1:0] hi;
  logic signed [VAL_W-1:0] val;
  logic                    degenerate;
  logic signed [VAL_W-1:0] new_min;
  logic signed [VAL_W-1:0] new_max;
  out_item_t               early_res;
  logic [VAL_W:0]          trial;
  logic [VAL_W-1:0]        div_val;
  out_item_t               div_res;

  always_comb begin
    rd_wide = {{ADDR_W{1'b0}}, in_data.feature_index};
    wr_wide = {{ADDR_W{1'b0}}, item_r.feature_index};
    rd_addr = rd_wide[ADDR_W-1:0];
    wr_addr = wr_wide[ADDR_W-1:0];
  end

  // active column count is feature_count limited to the table depth
  always_comb begin
    if (CNT_W'(fcount_r) > CNT_W'(MAX_FEATURES)) begin
      active = CNT_W'(MAX_FEATURES);
    end else begin
      active = CNT_W'(fcount_r);
    end
    bad = CNT_W'(item_r.feature_index) >= active;
  end

  // an entry never written since the last clear holds the empty pair
  always_comb begin
    val        = item_r.sample_value;
    lo         = rd_vld_r ? rd_min_r : VAL_MAX;
    hi         = rd_vld_r ? rd_max_r : VAL_MIN;
    degenerate = hi <= lo;
    new_min    = (val < lo) ? val : lo;
    new_max    = (val > hi) ? val : hi;
  end

  always_comb begin
    early_res.result_feature   = item_r.feature_index;
    early_res.result_value     = '0;
    early_res.range_degenerate = 1'b0;
    early_res.index_error      = 1'b0;
    if (bad) begin
      early_res.index_error = 1'b1;
    end else if (bypass_r) begin
      early_res.result_value = val;
    end else if (degenerate) begin
      early_res.range_degenerate = 1'b1;
    end
  end

  assign status.opcode = item_r.opcode;
  assign status.bad    = bad;
  assign status.early  = bad | bypass_r | degenerate;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bypass_r <= 1'b0;
      fcount_r <= FC_W'(16);
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_BYPASS:        bypass_r <= cfg_wdata[0];
        CFG_FEATURE_COUNT: fcount_r <= cfg_wdata[FC_W-1:0];
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.clr_stats) begin
      vld_r <= '0;
    end else if (cmd.wr_stats) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_stats) begin
      mem_min[wr_addr] <= new_min;
      mem_max[wr_addr] <= new_max;
    end
    if (cmd.load) begin
      item_r   <= in_data;
      rd_min_r <= mem_min[rd_addr];
      rd_max_r <= mem_max[rd_addr];
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  // restoring divide step: shift in next dividend bit, keep quotient bit
  always_comb begin
    trial = {rem_r, dvd_r[VAL_W-1]} - {1'b0, range_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      early_r     <= bad | bypass_r | degenerate;
      early_res_r <= early_res;
      diff_r      <= {val[VAL_W-1], val} - {lo[VAL_W-1], lo};
      range_r     <= VAL_W'(hi - lo);
    end
    if (cmd.abs_load) begin
      neg_r <= diff_r[VAL_W];
      mag_r <= diff_r[VAL_W] ? VAL_W'(-diff_r) : diff_r[VAL_W-1:0];
    end
    if (cmd.div_init) begin
      // quotient of 2^32 or more when the high half already reaches the range
      ovf_r <= VAL_W'(mag_r[VAL_W-1:FRAC_W]) >= range_r;
      rem_r <= VAL_W'(mag_r[VAL_W-1:FRAC_W]);
      dvd_r <= {mag_r[FRAC_W-1:0], {FRAC_W{1'b0}}};
    end else if (cmd.div_step) begin
      if (!trial[VAL_W]) begin
        rem_r <= trial[VAL_W-1:0];
        dvd_r <= {dvd_r[VAL_W-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[VAL_W-2:0], dvd_r[VAL_W-1]};
        dvd_r <= {dvd_r[VAL_W-2:0], 1'b0};
      end
    end
  end

  // truncated quotient, saturated to the signed range
  always_comb begin
    if (!neg_r) begin
      div_val = (ovf_r | dvd_r[VAL_W-1]) ? VAL_MAX : dvd_r;
    end else if (ovf_r | (dvd_r[VAL_W-1] & (|dvd_r[VAL_W-2:0]))) begin
      div_val = VAL_MIN;
    end else begin
      div_val = VAL_W'(-dvd_r);
    end
    div_res.result_value     = div_val;
    div_res.result_feature   = item_r.feature_index;
    div_res.range_degenerate = 1'b0;
    div_res.index_error      = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r <= early_r ? early_res_r : div_res;
    end
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

// File: rtl/core/mmfn_ctrl.sv
// sequencer for the normalizer: handshakes, divide step count, output valid
`default_nettype none
`include "min_max_feature_normalizer_defines.svh"
module mmfn_ctrl (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire                     out_ready,
  output mmfn_pkg::dp_cmd_t       cmd,
  input  wire  mmfn_pkg::dp_status_t status
);
  import mmfn_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ABS,
    ST_INIT,
    ST_DIV,
    ST_FIN
  } state_t;

  state_t                state_r;
  state_t                state_nxt;
  logic [STEP_CNT_W-1:0] cnt_r;
  logic [STEP_CNT_W-1:0] cnt_nxt;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  logic                  slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = ST_IDLE;
        case (status.opcode)
          OP_ACCUM: cmd.wr_stats  = !status.bad;
          OP_CLEAR: cmd.clr_stats = 1'b1;
          OP_NORM: begin
            cmd.eval  = 1'b1;
            state_nxt = status.early ? ST_FIN : ST_ABS;
          end
          default: ;
        endcase
      end
      ST_ABS: begin
        cmd.abs_load = 1'b1;
        state_nxt    = ST_INIT;
      end
      ST_INIT: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == STEP_CNT_W'(DIV_STEPS - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold until the output register can take the beat
        if (slot_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `MMFN_ASSERT_NXT(a_accept_goes_exec, clk, rst_n, in_valid && in_ready, state_r == ST_EXEC)
  `MMFN_ASSERT_NXT(a_div_ends, clk, rst_n,
    state_r == ST_DIV && cnt_r == STEP_CNT_W'(DIV_STEPS - 1), state_r == ST_FIN)
  `MMFN_ASSERT_NXT(a_fin_waits, clk, rst_n,
    state_r == ST_FIN && out_valid_r && !out_ready, state_r == ST_FIN && out_valid_r)
  `MMFN_ASSERT_IMP(a_no_overwrite, clk, rst_n, cmd.out_load, !out_valid_r || out_ready)

endmodule
`default_nettype wire
